### sv/rsse_pkg.sv
// ----------------------------------------------------------------------------
// rsse_pkg
// Shared constants for the radix seven-segment frame encoder: register
// indexes, field widths and the two segment tables.
// ----------------------------------------------------------------------------
`default_nettype none

package rsse_pkg;

	localparam int ValueWidth  = 32;
	localparam int RadixWidth  = 5;
	localparam int DigitWidth  = 4;
	localparam int FrameWidth  = 16;
	localparam int IndexWidth  = 3;

	// configuration register indexes
	localparam logic REG_RADIX    = 1'b0;
	localparam logic REG_POLARITY = 1'b1;

	localparam logic [RadixWidth-1:0] RADIX_RESET = 5'd10;
	localparam logic [RadixWidth-1:0] RADIX_MIN   = 5'd2;
	localparam logic [RadixWidth-1:0] RADIX_MAX   = 5'd16;

	localparam logic POLARITY_CATHODE = 1'b0;
	localparam logic POLARITY_ANODE   = 1'b1;

	typedef logic [7:0] seg_t;

	localparam seg_t SEG_CATHODE [16] = '{
		8'hfc, 8'h60, 8'hda, 8'hf2, 8'h66, 8'hb6, 8'hbe, 8'he0,
		8'hfe, 8'hf6, 8'hee, 8'h3e, 8'h1a, 8'h7a, 8'h9e, 8'h8e
	};

	localparam seg_t SEG_ANODE [16] = '{
		8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8,
		8'h80, 8'h90, 8'h88, 8'h83, 8'ha7, 8'ha1, 8'h86, 8'h8e
	};

endpackage

`default_nettype wire

### sv/radix_seven_segment_frame_encoder_unit.sv
// ----------------------------------------------------------------------------
// radix_seven_segment_frame_encoder_unit
// Splits a 32-bit number into DIGIT_COUNT digits of a programmable radix and
// emits one select/segment shift word per digit.
//
// Input channel: value with value_valid / value_stall. Output channel:
// frame_word, digit_index, last with frame_valid / frame_stall. A transfer
// happens at a clock edge where valid is high and stall is low.
// Each number yields DIGIT_COUNT words, least significant digit first, last
// set on the final one. Configuration (radix, display_polarity) goes through
// wr_en / wr_index / wr_data; the user must do so only while the unit is
// idle, which the unit itself does not enforce. Digits come from a
// long-division pipeline of 4*DIGIT_COUNT stages, each stage retiring eight
// quotient bits with a chain of compare/subtract steps. The pipeline can
// hold a number in every stage, but it advances and takes a new number only
// while the output word serializer is empty or passing its last word; while
// frame_stall is low the serializer emits one word per cycle.
// Reset clears all valid bits and loads radix 10, common cathode.
// While frame_stall is high the current word holds and the pipeline freezes
// behind it; value_stall rises once the serializer can take no new number.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_seven_segment_frame_encoder_unit
	import rsse_pkg::*;
#(
	parameter int DIGIT_COUNT = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic                  wr_index,
	input  wire logic [RadixWidth-1:0] wr_data,
	input  wire logic                  value_valid,
	output logic                       value_stall,
	input  wire logic [ValueWidth-1:0] value,
	output logic                       frame_valid,
	input  wire logic                  frame_stall,
	output logic [FrameWidth-1:0]      frame_word,
	output logic [IndexWidth-1:0]      digit_index,
	output logic                       last
);

	localparam int STAGES = 4 * DIGIT_COUNT;

	typedef logic [DIGIT_COUNT-1:0][DigitWidth-1:0] digits_t;

	// configuration
	logic [RadixWidth-1:0] radix_q;
	logic                  polarity_q;
	logic [RadixWidth-1:0] radix_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q    <= RADIX_RESET;
			polarity_q <= POLARITY_CATHODE;
		end else if (wr_en) begin
			case (wr_index)
				REG_RADIX:    radix_q    <= wr_data;
				REG_POLARITY: polarity_q <= wr_data[0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		if (radix_q < RADIX_MIN)
			radix_eff = RADIX_MIN;
		else if (radix_q > RADIX_MAX)
			radix_eff = RADIX_MAX;
		else
			radix_eff = radix_q;
	end

	// division pipeline
	logic                  vld_s  [STAGES];
	logic [ValueWidth-1:0] word_s [STAGES];
	logic [DigitWidth-1:0] rem_s  [STAGES];
	digits_t               dig_s  [STAGES];

	logic adv;

	// serializer / output register
	logic                  ser_valid_q;
	digits_t               ser_dig_q;
	logic [IndexWidth-1:0] cnt_q;
	logic                  is_last;
	logic                  out_xfer;

	assign is_last  = (cnt_q == IndexWidth'(DIGIT_COUNT - 1));
	assign out_xfer = ser_valid_q && !frame_stall;
	assign adv      = !ser_valid_q || (out_xfer && is_last);

	assign value_stall = !adv;

	for (genvar s = 0; s < STAGES; s++) begin : g_stage
		localparam int C = s % 4;   // byte of the word, high byte first
		localparam int K = s / 4;   // digit being produced

		logic                  v_in;
		logic [ValueWidth-1:0] w_in;
		logic [DigitWidth-1:0] r_in;
		digits_t               d_in;
		logic [ValueWidth-1:0] w_nxt;
		logic [DigitWidth-1:0] r_nxt;
		digits_t               d_nxt;

		if (s == 0) begin : g_head
			assign v_in = value_valid;
			assign w_in = value;
			assign r_in = '0;
			assign d_in = '0;
		end else begin : g_body
			assign v_in = vld_s[s-1];
			assign w_in = word_s[s-1];
			assign r_in = rem_s[s-1];
			assign d_in = dig_s[s-1];
		end

		// eight restoring-division steps; quotient bits overwrite dividend bits
		always_comb begin
			logic [DigitWidth-1:0] rem;
			logic [RadixWidth-1:0] t;
			w_nxt = w_in;
			rem   = (C == 0) ? '0 : r_in;
			for (int b = 0; b < 8; b++) begin
				t = {rem, w_in[ValueWidth-1-8*C-b]};
				if (t >= radix_eff) begin
					t = t - radix_eff;
					w_nxt[ValueWidth-1-8*C-b] = 1'b1;
				end else begin
					w_nxt[ValueWidth-1-8*C-b] = 1'b0;
				end
				rem = t[DigitWidth-1:0];
			end
			r_nxt = rem;
			d_nxt = d_in;
			if (C == 3)
				d_nxt[K] = rem;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[s] <= 1'b0;
			else if (adv)
				vld_s[s] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				word_s[s] <= w_nxt;
				rem_s[s]  <= r_nxt;
				dig_s[s]  <= d_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else if (adv) begin
			ser_valid_q <= vld_s[STAGES-1];
			cnt_q       <= '0;
		end else if (out_xfer) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			ser_dig_q <= dig_s[STAGES-1];
		else if (out_xfer)
			ser_dig_q <= ser_dig_q >> DigitWidth;
	end

	// word formatting from the held digit
	logic [DigitWidth-1:0] cur_digit;
	logic [7:0]            sel_bin;
	logic [7:0]            sel_hot;

	assign cur_digit = ser_dig_q[0];
	assign sel_bin   = 8'(DIGIT_COUNT - 1) - {5'b0, cnt_q};
	assign sel_hot   = 8'd1 << cnt_q;

	always_comb begin
		case (polarity_q)
			POLARITY_CATHODE: frame_word = {sel_bin, SEG_CATHODE[cur_digit]};
			POLARITY_ANODE:   frame_word = {SEG_ANODE[cur_digit], sel_hot};
			default:          frame_word = {sel_bin, SEG_CATHODE[cur_digit]};
		endcase
	end

	assign frame_valid = ser_valid_q;
	assign digit_index = cnt_q;
	assign last        = is_last;

endmodule

`default_nettype wire
